### sv/sit_pkg.sv
// Shared types and constants for the segment intersection test pipeline.
package sit_pkg;

    // Four orientation tests: C and D against AB, then A and B against CD.
    localparam int unsigned NUM_ORIENT = 4;

    typedef enum logic [1:0] {
        ORI_ABC = 2'd0,
        ORI_ABD = 2'd1,
        ORI_CDA = 2'd2,
        ORI_CDB = 2'd3
    } orient_idx_t;

    // Per-orientation flags carried out of the determinant stage.
    typedef struct packed {
        logic [NUM_ORIENT-1:0] neg;
        logic [NUM_ORIENT-1:0] zero;
        logic [NUM_ORIENT-1:0] touch;
        logic                  box_ok;
    } orient_flags_t;

endpackage

### sv/segment_intersect_test_top.sv
// Pipelined test whether two closed 2D segments cross or touch.
// m_valid comes from the last of four register stages; one word per cycle while m_ready does not stall.
// Stages are differences and box limits, the eight signed multiplies with box compares,
// the determinant subtracts, and the final combine into the output register.
// Each stage holds its own valid bit, so a stall at m_ready fills bubbles before it backs up.
// aresetn is synchronous and active low; it clears all valid bits.
module segment_intersect_test_top
    import sit_pkg::*;
#(
    parameter int unsigned COORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_ax,
    input  logic [31:0] s_ay,
    input  logic [31:0] s_bx,
    input  logic [31:0] s_by_,
    input  logic [31:0] s_cx,
    input  logic [31:0] s_cy,
    input  logic [31:0] s_dx,
    input  logic [31:0] s_dy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit
);

    localparam int unsigned W  = COORD_BITS;
    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * DW;

    // Stage handshake: a stage loads when it is empty or its contents move on.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- Stage 1: differences and box limits ----------------
    logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = $signed(s_ax[W-1:0]);
    assign ay = $signed(s_ay[W-1:0]);
    assign bx = $signed(s_bx[W-1:0]);
    assign by = $signed(s_by_[W-1:0]);
    assign cx = $signed(s_cx[W-1:0]);
    assign cy = $signed(s_cy[W-1:0]);
    assign dx = $signed(s_dx[W-1:0]);
    assign dy = $signed(s_dy[W-1:0]);

    logic signed [DW-1:0] qpx_next [NUM_ORIENT];
    logic signed [DW-1:0] rpy_next [NUM_ORIENT];
    logic signed [DW-1:0] qpy_next [NUM_ORIENT];
    logic signed [DW-1:0] rpx_next [NUM_ORIENT];
    logic signed [W-1:0]  rx_next  [NUM_ORIENT];
    logic signed [W-1:0]  ry_next  [NUM_ORIENT];
    logic signed [W-1:0]  ab_xlo_next, ab_xhi_next, ab_ylo_next, ab_yhi_next;
    logic signed [W-1:0]  cd_xlo_next, cd_xhi_next, cd_ylo_next, cd_yhi_next;

    logic signed [DW-1:0] qpx_reg [NUM_ORIENT];
    logic signed [DW-1:0] rpy_reg [NUM_ORIENT];
    logic signed [DW-1:0] qpy_reg [NUM_ORIENT];
    logic signed [DW-1:0] rpx_reg [NUM_ORIENT];
    logic signed [W-1:0]  rx_reg  [NUM_ORIENT];
    logic signed [W-1:0]  ry_reg  [NUM_ORIENT];
    logic signed [W-1:0]  ab_xlo_reg, ab_xhi_reg, ab_ylo_reg, ab_yhi_reg;
    logic signed [W-1:0]  cd_xlo_reg, cd_xhi_reg, cd_ylo_reg, cd_yhi_reg;

    always_comb begin
        logic signed [W-1:0] px [NUM_ORIENT];
        logic signed [W-1:0] py [NUM_ORIENT];
        logic signed [W-1:0] qx [NUM_ORIENT];
        logic signed [W-1:0] qy [NUM_ORIENT];
        logic signed [W-1:0] rx [NUM_ORIENT];
        logic signed [W-1:0] ry [NUM_ORIENT];

        // Orientation k is the sign of (q-p)x(r-p); r is also the touch candidate.
        px[ORI_ABC] = ax; py[ORI_ABC] = ay; qx[ORI_ABC] = bx; qy[ORI_ABC] = by;
        rx[ORI_ABC] = cx; ry[ORI_ABC] = cy;
        px[ORI_ABD] = ax; py[ORI_ABD] = ay; qx[ORI_ABD] = bx; qy[ORI_ABD] = by;
        rx[ORI_ABD] = dx; ry[ORI_ABD] = dy;
        px[ORI_CDA] = cx; py[ORI_CDA] = cy; qx[ORI_CDA] = dx; qy[ORI_CDA] = dy;
        rx[ORI_CDA] = ax; ry[ORI_CDA] = ay;
        px[ORI_CDB] = cx; py[ORI_CDB] = cy; qx[ORI_CDB] = dx; qy[ORI_CDB] = dy;
        rx[ORI_CDB] = bx; ry[ORI_CDB] = by;

        for (int k = 0; k < NUM_ORIENT; k++) begin
            qpx_next[k] = $signed({qx[k][W-1], qx[k]}) - $signed({px[k][W-1], px[k]});
            rpy_next[k] = $signed({ry[k][W-1], ry[k]}) - $signed({py[k][W-1], py[k]});
            qpy_next[k] = $signed({qy[k][W-1], qy[k]}) - $signed({py[k][W-1], py[k]});
            rpx_next[k] = $signed({rx[k][W-1], rx[k]}) - $signed({px[k][W-1], px[k]});
            rx_next[k]  = rx[k];
            ry_next[k]  = ry[k];
        end

        ab_xlo_next = (ax < bx) ? ax : bx;
        ab_xhi_next = (ax > bx) ? ax : bx;
        ab_ylo_next = (ay < by) ? ay : by;
        ab_yhi_next = (ay > by) ? ay : by;
        cd_xlo_next = (cx < dx) ? cx : dx;
        cd_xhi_next = (cx > dx) ? cx : dx;
        cd_ylo_next = (cy < dy) ? cy : dy;
        cd_yhi_next = (cy > dy) ? cy : dy;
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            for (int k = 0; k < NUM_ORIENT; k++) begin
                qpx_reg[k] <= qpx_next[k];
                rpy_reg[k] <= rpy_next[k];
                qpy_reg[k] <= qpy_next[k];
                rpx_reg[k] <= rpx_next[k];
                rx_reg[k]  <= rx_next[k];
                ry_reg[k]  <= ry_next[k];
            end
            ab_xlo_reg <= ab_xlo_next;
            ab_xhi_reg <= ab_xhi_next;
            ab_ylo_reg <= ab_ylo_next;
            ab_yhi_reg <= ab_yhi_next;
            cd_xlo_reg <= cd_xlo_next;
            cd_xhi_reg <= cd_xhi_next;
            cd_ylo_reg <= cd_ylo_next;
            cd_yhi_reg <= cd_yhi_next;
        end
    end

    // ---------------- Stage 2: products and box compares ----------------
    logic signed [PW-1:0]  prod1_next [NUM_ORIENT];
    logic signed [PW-1:0]  prod2_next [NUM_ORIENT];
    logic [NUM_ORIENT-1:0] touch_next;
    logic                  box_ok_next;

    logic signed [PW-1:0]  prod1_reg [NUM_ORIENT];
    logic signed [PW-1:0]  prod2_reg [NUM_ORIENT];
    logic [NUM_ORIENT-1:0] touch2_reg;
    logic                  box_ok2_reg;

    always_comb begin
        for (int k = 0; k < NUM_ORIENT; k++) begin
            prod1_next[k] = PW'(qpx_reg[k]) * PW'(rpy_reg[k]);
            prod2_next[k] = PW'(qpy_reg[k]) * PW'(rpx_reg[k]);
        end
        // The first two tests check C and D against AB's box, the last two A and B
        // against CD's box.
        for (int k = 0; k < NUM_ORIENT; k++) begin
            if (k < 2) begin
                touch_next[k] = (rx_reg[k] >= ab_xlo_reg) && (rx_reg[k] <= ab_xhi_reg) &&
                                (ry_reg[k] >= ab_ylo_reg) && (ry_reg[k] <= ab_yhi_reg);
            end else begin
                touch_next[k] = (rx_reg[k] >= cd_xlo_reg) && (rx_reg[k] <= cd_xhi_reg) &&
                                (ry_reg[k] >= cd_ylo_reg) && (ry_reg[k] <= cd_yhi_reg);
            end
        end
        box_ok_next = (ab_xlo_reg <= cd_xhi_reg) && (cd_xlo_reg <= ab_xhi_reg) &&
                      (ab_ylo_reg <= cd_yhi_reg) && (cd_ylo_reg <= ab_yhi_reg);
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            for (int k = 0; k < NUM_ORIENT; k++) begin
                prod1_reg[k] <= prod1_next[k];
                prod2_reg[k] <= prod2_next[k];
            end
            touch2_reg  <= touch_next;
            box_ok2_reg <= box_ok_next;
        end
    end

    // ---------------- Stage 3: determinant signs ----------------
    orient_flags_t flags_next;
    orient_flags_t flags_reg;

    always_comb begin
        logic signed [PW:0] det;
        det = '0;
        for (int k = 0; k < NUM_ORIENT; k++) begin
            det = $signed({prod1_reg[k][PW-1], prod1_reg[k]}) -
                  $signed({prod2_reg[k][PW-1], prod2_reg[k]});
            flags_next.neg[k]  = det[PW];
            flags_next.zero[k] = (det == '0);
        end
        flags_next.touch  = touch2_reg;
        flags_next.box_ok = box_ok2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            flags_reg <= flags_next;
        end
    end

    // ---------------- Stage 4: combine into the output register ----------------
    logic hit_next;
    logic hit_reg;

    always_comb begin
        logic opp_ab, opp_cd, touch_any;
        opp_ab = !flags_reg.zero[ORI_ABC] && !flags_reg.zero[ORI_ABD] &&
                 (flags_reg.neg[ORI_ABC] != flags_reg.neg[ORI_ABD]);
        opp_cd = !flags_reg.zero[ORI_CDA] && !flags_reg.zero[ORI_CDB] &&
                 (flags_reg.neg[ORI_CDA] != flags_reg.neg[ORI_CDB]);
        touch_any = |(flags_reg.zero & flags_reg.touch);
        hit_next  = flags_reg.box_ok && ((opp_ab && opp_cd) || touch_any);
    end

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            hit_reg <= hit_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_hit   = hit_reg;

endmodule

### tb/sv/segment_hit_monitor.sv
// Channel monitor that predicts and checks the segment hit result of every accepted word.
`timescale 1ns / 100ps

module segment_hit_monitor #(
    parameter int unsigned COORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_ax,
    input  logic [31:0] s_ay,
    input  logic [31:0] s_bx,
    input  logic [31:0] s_by_,
    input  logic [31:0] s_cx,
    input  logic [31:0] s_cy,
    input  logic [31:0] s_dx,
    input  logic [31:0] s_dy,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_hit,
    output int          n_errors,
    output int          n_pending,
    output int          n_results,
    output int          n_hits
);

    typedef struct {
        bit          hit;
        int unsigned seq;
    } hit_expect_t;

    hit_expect_t expected_hits[$];
    int unsigned n_accepted;

    // Keep the low COORD_BITS bits and sign-extend from the top one of them.
    function automatic longint widen(input logic [31:0] v);
        logic [63:0] u;
        u = {32'b0, v} << (64 - COORD_BITS);
        return $signed(u) >>> (64 - COORD_BITS);
    endfunction

    function automatic longint lo_of(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint hi_of(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // Sign of (q-p)x(r-p); the products need about 70 bits, so work at 128.
    function automatic int orient_sign(input longint px, input longint py,
                                       input longint qx, input longint qy,
                                       input longint rx, input longint ry);
        logic signed [127:0] e_qx, e_qy, e_rx, e_ry, det;
        e_qx = qx - px;
        e_qy = qy - py;
        e_rx = rx - px;
        e_ry = ry - py;
        det = e_qx * e_ry - e_qy * e_rx;
        if (det == 0)
            return 0;
        return (det < 0) ? -1 : 1;
    endfunction

    function automatic bit in_box(input longint px, input longint py,
                                  input longint ux, input longint uy,
                                  input longint vx, input longint vy);
        return px >= lo_of(ux, vx) && px <= hi_of(ux, vx) &&
               py >= lo_of(uy, vy) && py <= hi_of(uy, vy);
    endfunction

    function automatic bit predict_hit(input logic [31:0] r_ax, input logic [31:0] r_ay,
                                       input logic [31:0] r_bx, input logic [31:0] r_by,
                                       input logic [31:0] r_cx, input logic [31:0] r_cy,
                                       input logic [31:0] r_dx, input logic [31:0] r_dy);
        longint a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
        int abc, abd, cda, cdb;
        a_x = widen(r_ax);
        a_y = widen(r_ay);
        b_x = widen(r_bx);
        b_y = widen(r_by);
        c_x = widen(r_cx);
        c_y = widen(r_cy);
        d_x = widen(r_dx);
        d_y = widen(r_dy);
        if (!(lo_of(a_x, b_x) <= hi_of(c_x, d_x) && lo_of(c_x, d_x) <= hi_of(a_x, b_x) &&
              lo_of(a_y, b_y) <= hi_of(c_y, d_y) && lo_of(c_y, d_y) <= hi_of(a_y, b_y)))
            return 1'b0;
        abc = orient_sign(a_x, a_y, b_x, b_y, c_x, c_y);
        abd = orient_sign(a_x, a_y, b_x, b_y, d_x, d_y);
        cda = orient_sign(c_x, c_y, d_x, d_y, a_x, a_y);
        cdb = orient_sign(c_x, c_y, d_x, d_y, b_x, b_y);
        return (abc * abd < 0 && cda * cdb < 0) ||
               (abc == 0 && in_box(c_x, c_y, a_x, a_y, b_x, b_y)) ||
               (abd == 0 && in_box(d_x, d_y, a_x, a_y, b_x, b_y)) ||
               (cda == 0 && in_box(a_x, a_y, c_x, c_y, d_x, d_y)) ||
               (cdb == 0 && in_box(b_x, b_y, c_x, c_y, d_x, d_y));
    endfunction

    always @(posedge aclk) begin : watch_channels
        hit_expect_t e;
        if (!aresetn) begin
            expected_hits.delete();
            n_accepted = 0;
        end else begin
            if (s_valid && s_ready) begin
                e.hit = predict_hit(s_ax, s_ay, s_bx, s_by_, s_cx, s_cy, s_dx, s_dy);
                e.seq = n_accepted;
                expected_hits.insert(expected_hits.size(), e);
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (m_hit === 1'b1)
                    n_hits++;
                if (expected_hits.size() == 0) begin
                    if (n_errors < 10)
                        $display("[%0t] result word hit=%b arrived with nothing expected",
                                 $realtime, m_hit);
                    n_errors++;
                end else begin
                    e = expected_hits[0];
                    expected_hits.delete(0);
                    if (m_hit !== e.hit) begin
                        if (n_errors < 10)
                            $display("[%0t] pair #%0d: hit expected %b, got %b",
                                     $realtime, e.seq, e.hit, m_hit);
                        n_errors++;
                    end
                end
            end
        end
        n_pending = expected_hits.size();
    end

endmodule

### tb/sv/segment_intersect_test_top_test.sv
// Stimulus and verdict for the segment intersection test block.
`timescale 1ns / 100ps

module segment_intersect_test_top_test;

    localparam int unsigned COORD_BITS   = 32;
    localparam int          RANDOM_PAIRS = 1880;
    localparam int          QUIET_PAIRS  = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [31:0] ax, ay, bx, by_, cx, cy, dx, dy;
    } seg_pair_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_ax = '0, s_ay = '0, s_bx = '0, s_by_ = '0;
    logic [31:0] s_cx = '0, s_cy = '0, s_dx = '0, s_dy = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;

    bit          src_idle_on;
    bit          snk_idle_on;
    int unsigned src_gap_odds;
    int unsigned snk_stall_odds;
    int unsigned cycle_count;
    int          n_sent;
    int          n_directed;
    int          n_errors, n_pending, n_results, n_hits;

    always #5 aclk = ~aclk;

    segment_intersect_test_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ax   (s_ax),
        .s_ay   (s_ay),
        .s_bx   (s_bx),
        .s_by_  (s_by_),
        .s_cx   (s_cx),
        .s_cy   (s_cy),
        .s_dx   (s_dx),
        .s_dy   (s_dy),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_hit  (m_hit)
    );

    segment_hit_monitor #(
        .COORD_BITS(COORD_BITS)
    ) u_hit_monitor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_ax     (s_ax),
        .s_ay     (s_ay),
        .s_bx     (s_bx),
        .s_by_    (s_by_),
        .s_cx     (s_cx),
        .s_cy     (s_cy),
        .s_dx     (s_dx),
        .s_dy     (s_dy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_hit    (m_hit),
        .n_errors (n_errors),
        .n_pending(n_pending),
        .n_results(n_results),
        .n_hits   (n_hits)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, n_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, none when snk_idle_on is clear.
    always begin : ready_stalls
        int unsigned burst;
        @(negedge aclk);
        if (snk_idle_on && $urandom_range(0, 99) < snk_stall_odds) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
        end
        m_ready <= 1'b1;
    end

    function automatic int srange(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 7))
            0: return CMIN;
            1: return CMIN + 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'd1;
            5: return CMAX - 32'd1;
            6: return CMAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic seg_pair_t directed_pair(input int idx);
        seg_pair_t p;
        case (idx)
            0:  p = '{-10, -10, 10, 10, -10, 10, 10, -10};
            1:  p = '{0, 0, 1, 1, 5, 5, 6, 7};
            2:  p = '{0, 0, 10, 10, 1, 0, 10, 8};
            3:  p = '{0, 0, 10, 0, 5, 0, 5, 10};
            4:  p = '{0, 0, 4, 4, 4, 4, 9, -3};
            5:  p = '{5, 5, 5, 5, 0, 0, 10, 10};
            6:  p = '{5, 6, 5, 6, 0, 0, 10, 10};
            7:  p = '{3, -3, 3, -3, 3, -3, 3, -3};
            8:  p = '{3, -3, 3, -3, 3, -2, 3, -2};
            9:  p = '{0, 0, 10, 0, 5, 0, 20, 0};
            10: p = '{0, 0, 10, 10, 10, 10, 20, 20};
            11: p = '{7, -5, 7, 5, 7, -1, 7, 1};
            12: p = '{0, 0, 10, 0, 11, 0, 20, 0};
            13: p = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN};
            14: p = '{CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX};
            15: p = '{CMIN, CMIN, CMAX, CMAX, CMIN + 32'd1, CMIN, CMAX, CMAX - 32'd1};
            16: p = '{CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 32'd1, CMAX - 32'd1, CMAX};
            17: p = '{0, 0, 0, 0, 0, 0, 0, 0};
            18: p = '{-1, -1, -1, -1, -1, -1, -1, -1};
            19: p = '{CMIN, CMAX, CMAX, CMIN, 0, -1, CMAX, CMAX};
            20: p = '{CMIN, 0, CMAX, 0, CMAX, 0, CMAX, 5};
            21: p = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555};
            default: p = '{-3, 0, 3, 0, 0, -3, 0, 3};
        endcase
        return p;
    endfunction

    // Mix of shapes: wide random pairs rarely touch, so collinear runs, shared
    // points, crossings and tiny grids are built on purpose.
    function automatic seg_pair_t random_pair();
        seg_pair_t   p;
        int          kind, bx0, by0, ux, uy, vx, vy, m, t;
        logic [31:0] sx, sy;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            p = '{$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        end else if (kind < 50) begin
            p = '{srange(-6, 6), srange(-6, 6), srange(-6, 6), srange(-6, 6),
                  srange(-6, 6), srange(-6, 6), srange(-6, 6), srange(-6, 6)};
            if ($urandom_range(0, 9) == 0) begin
                p.bx  = p.ax;
                p.by_ = p.ay;
            end
        end else if (kind < 62) begin
            // Four points on one line, with the base anywhere in the plane.
            bx0 = ($urandom_range(0, 3) == 0) ? int'($urandom) : srange(-1000000, 1000000);
            by0 = ($urandom_range(0, 3) == 0) ? int'($urandom) : srange(-1000000, 1000000);
            ux = srange(-40, 40);
            uy = srange(-40, 40);
            p.ax = bx0 + srange(-60, 60) * ux;
            p.ay = by0;
            p.ay = p.ay + ((p.ax - bx0) == 0 ? 0 : 0);
            m = srange(-60, 60);
            p.ax = bx0 + m * ux;
            p.ay = by0 + m * uy;
            m = srange(-60, 60);
            p.bx = bx0 + m * ux;
            p.by_ = by0 + m * uy;
            m = srange(-60, 60);
            p.cx = bx0 + m * ux;
            p.cy = by0 + m * uy;
            m = srange(-60, 60);
            p.dx = bx0 + m * ux;
            p.dy = by0 + m * uy;
        end else if (kind < 74) begin
            // An endpoint of one segment placed exactly on the other.
            ux = srange(-30, 30);
            uy = srange(-30, 30);
            m = srange(1, 20);
            t = srange(0, m);
            p.ax = srange(-1000, 1000);
            p.ay = srange(-1000, 1000);
            p.bx = p.ax + m * ux;
            p.by_ = p.ay + m * uy;
            p.cx = p.ax + t * ux;
            p.cy = p.ay + t * uy;
            p.dx = srange(-1000, 1000);
            p.dy = srange(-1000, 1000);
            if ($urandom_range(0, 1)) begin
                sx = p.cx; sy = p.cy; p.cx = p.dx; p.cy = p.dy; p.dx = sx; p.dy = sy;
            end
            if ($urandom_range(0, 1)) begin
                sx = p.ax; sy = p.ay; p.ax = p.cx; p.ay = p.cy; p.cx = sx; p.cy = sy;
                sx = p.bx; sy = p.by_; p.bx = p.dx; p.by_ = p.dy; p.dx = sx; p.dy = sy;
            end
        end else if (kind < 86) begin
            // Two segments about a common center, at large magnitudes, with D's x nudged by up to one.
            bx0 = srange(-(1 << 29), 1 << 29);
            by0 = srange(-(1 << 29), 1 << 29);
            ux = srange(-(1 << 29), 1 << 29);
            uy = srange(-(1 << 29), 1 << 29);
            vx = srange(-(1 << 29), 1 << 29);
            vy = srange(-(1 << 29), 1 << 29);
            p = '{bx0 - ux, by0 - uy, bx0 + ux, by0 + uy,
                  bx0 - vx, by0 - vy, bx0 + vx + srange(-1, 1), by0 + vy};
            if ($urandom_range(0, 3) == 0) begin
                p.dx = p.cx;
                p.dy = p.cy;
            end
        end else begin
            p = '{edge_value(), edge_value(), edge_value(), edge_value(),
                  edge_value(), edge_value(), edge_value(), edge_value()};
        end
        return p;
    endfunction

    task automatic input_gap(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic send_pair(input seg_pair_t p);
        if (src_idle_on && $urandom_range(0, 99) < src_gap_odds)
            input_gap($urandom_range(1, 12));
        @(negedge aclk);
        s_valid <= 1'b1;
        s_ax    <= p.ax;
        s_ay    <= p.ay;
        s_bx    <= p.bx;
        s_by_   <= p.by_;
        s_cx    <= p.cx;
        s_cy    <= p.cy;
        s_dx    <= p.dx;
        s_dy    <= p.dy;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic drain_results();
        input_gap(1);
        while (n_pending != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        int k;
        src_idle_on    = 1'b1;
        snk_idle_on    = 1'b1;
        src_gap_odds   = 20;
        snk_stall_odds = 15;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < 23; k++)
            send_pair(directed_pair(k));
        n_directed = n_sent;

        // Let the pipeline empty completely, then hold off a little before resuming.
        drain_results();
        repeat (8) @(negedge aclk);

        for (k = 0; k < RANDOM_PAIRS; k++) begin
            if (k % 200 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin src_gap_odds = 0;  snk_stall_odds = 0;  end
                    1: begin src_gap_odds = 10; snk_stall_odds = 30; end
                    2: begin src_gap_odds = 40; snk_stall_odds = 10; end
                    default: begin src_gap_odds = 60; snk_stall_odds = 60; end
                endcase
            end
            if (k == RANDOM_PAIRS / 2)
                drain_results();
            if (k == RANDOM_PAIRS - QUIET_PAIRS) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            send_pair(random_pair());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d segment pairs (%0d directed): extremes, crossings, touches,",
                 n_sent, n_directed);
        $display("collinear and point-like segments; %0d results checked, %0d of them hits.",
                 n_results, n_hits);
        if (n_errors == 0 && n_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
